[sv/ile_pkg.sv]
// Shared definitions for the indexed list engine.
// Command and status codes plus the default store capacity.
// No dependencies.
package ile_pkg;

  localparam int CAPACITY_DEF = 256;

  typedef enum logic [3:0] {
    CMD_INSERT_AT    = 4'd0,
    CMD_PUSH_FRONT   = 4'd1,
    CMD_PUSH_BACK    = 4'd2,
    CMD_ERASE_AT     = 4'd3,
    CMD_POP_FRONT    = 4'd4,
    CMD_POP_BACK     = 4'd5,
    CMD_FIND         = 4'd6,
    CMD_REMOVE_FIRST = 4'd7,
    CMD_REMOVE_ALL   = 4'd8
  } command_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

endpackage

[sv/ile_if.sv]
// Valid/ready channel interfaces for the indexed list engine.
// Command channel in, response channel out; fixed field widths, no dependencies.
interface ile_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic [8:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

interface ile_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] found_index;
  logic [8:0] count;

  modport source (output valid, output status, output found_index, output count, input ready);
  modport sink   (input valid, input status, input found_index, input count, output ready);
endinterface

[sv/indexed_list_engine.sv]
// Indexed list engine: ordered list of 32-bit values in a store with one read and one write port.
// Depends on ile_pkg and the channel interfaces in ile_if.sv.
//
//   channel | dir | beat carries
//   --------+-----+-------------------------------------------
//   cmd     | in  | command, position, value
//   rsp     | out | status, found_index, count (one per command)
//
// A command walks the store one entry per cycle: an insert shifts the entries from the
// position up and writes the value; an erase shifts the later entries down; find and
// remove-first scan from the front, and a removal then shifts down over the match;
// remove-all copies the kept entries forward. Failed checks go straight to S_FIN.
// Reset clears the length and the control state; the store is never cleared.
// A new command is taken while a response waits; a stalled response holds the engine in S_FIN.
module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  ile_cmd_if.sink  cmd,
  ile_rsp_if.source rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int XW = (LW > 9) ? LW : 9;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_UP   = 7'b0000010,
    S_PUT  = 7'b0000100,
    S_DOWN = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_PACK = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t        state;
  logic [LW-1:0] len;
  logic          is_find;
  logic [IW-1:0] pos;
  logic [31:0]   v;
  logic [LW-1:0] rp;
  logic [LW-1:0] rd_last;
  logic          rd_dn;
  logic          rd_go;
  logic          pv;
  logic [IW-1:0] pa;
  logic [LW-1:0] wp;
  status_t       res_status;
  logic [IW-1:0] res_found;

  logic          out_valid;
  status_t       out_status;
  logic [7:0]    out_found;
  logic [8:0]    out_count;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic [IW-1:0] mem_ra;

  logic [XW-1:0] len_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] ins_p;
  logic [XW-1:0] era_p;
  logic [XW-1:0] era_nx;
  logic [XW-1:0] found_x;
  logic [LW-1:0] pa_nx;
  logic          walk;
  logic          keep;

  assign cmd.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_index = out_found;
  assign rsp.count       = out_count;

  // Decode helpers for the command checks
  always_comb begin
    len_x = XW'(len);
    pos_x = XW'(cmd.position);
    unique case (command_t'(cmd.command))
      CMD_PUSH_FRONT: ins_p = '0;
      CMD_PUSH_BACK:  ins_p = len_x;
      default:        ins_p = pos_x;
    endcase
    era_p   = (command_t'(cmd.command) == CMD_POP_FRONT) ? '0 : pos_x;
    era_nx  = era_p + XW'(1);
    found_x = XW'(res_found);
  end

  assign pa_nx = LW'(pa) + LW'(1);
  assign walk  = (state == S_UP) || (state == S_DOWN) || (state == S_SCAN) ||
                 (state == S_PACK);
  assign keep  = (rdata != v);

  // Memory port control; walks only write entries already read
  always_comb begin
    mem_ra = rp[IW-1:0];
    mem_we = 1'b0;
    mem_wa = pos;
    mem_wd = rdata;
    unique case (state)
      S_UP: begin
        mem_we = pv;
        mem_wa = pa + IW'(1);
      end
      S_DOWN: begin
        mem_we = pv;
        mem_wa = pa - IW'(1);
      end
      S_PACK: begin
        mem_we = pv && keep;
        mem_wa = wp[IW-1:0];
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = pos;
        mem_wd = v;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Store with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      rd_go     <= 1'b0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop the response once taken
      if (out_valid && rsp.ready) out_valid <= 1'b0;

      // advance the read pointer of a walk
      if (walk) begin
        pv <= rd_go;
        pa <= rp[IW-1:0];
        if (rd_go) begin
          if (rp == rd_last) rd_go <= 1'b0;
          else if (rd_dn) rp <= rp - LW'(1);
          else rp <= rp + LW'(1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            v          <= cmd.value;
            is_find    <= (command_t'(cmd.command) == CMD_FIND);
            res_found  <= '0;
            res_status <= ST_OK;
            pv         <= 1'b0;
            state      <= S_FIN;
            unique case (command_t'(cmd.command))
              CMD_INSERT_AT, CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (ins_p > len_x) begin
                  res_status <= ST_BAD_INDEX;
                end else if (len == CAP_L) begin
                  res_status <= ST_FULL;
                end else begin
                  pos <= ins_p[IW-1:0];
                  if (ins_p < len_x) begin
                    rp      <= len - LW'(1);
                    rd_last <= ins_p[LW-1:0];
                    rd_dn   <= 1'b1;
                    rd_go   <= 1'b1;
                    state   <= S_UP;
                  end else begin
                    state <= S_PUT;
                  end
                end
              end
              CMD_ERASE_AT, CMD_POP_FRONT: begin
                if (len == '0) begin
                  res_status <= ST_EMPTY;
                end else if (era_p >= len_x) begin
                  res_status <= ST_BAD_INDEX;
                end else begin
                  pos <= era_p[IW-1:0];
                  if (era_nx < len_x) begin
                    rp      <= era_nx[LW-1:0];
                    rd_last <= len - LW'(1);
                    rd_dn   <= 1'b0;
                    rd_go   <= 1'b1;
                    state   <= S_DOWN;
                  end else begin
                    len <= len - LW'(1);
                  end
                end
              end
              CMD_POP_BACK: begin
                if (len == '0) res_status <= ST_EMPTY;
                else len <= len - LW'(1);
              end
              CMD_FIND, CMD_REMOVE_FIRST: begin
                if (len == '0) begin
                  res_status <= ST_NOT_FOUND;
                end else begin
                  rp      <= '0;
                  rd_last <= len - LW'(1);
                  rd_dn   <= 1'b0;
                  rd_go   <= 1'b1;
                  state   <= S_SCAN;
                end
              end
              CMD_REMOVE_ALL: begin
                if (len != '0) begin
                  rp      <= '0;
                  wp      <= '0;
                  rd_last <= len - LW'(1);
                  rd_dn   <= 1'b0;
                  rd_go   <= 1'b1;
                  state   <= S_PACK;
                end
              end
              default: res_status <= ST_OK;
            endcase
          end
        end

        // shift entries up, then drop the new value in
        S_UP: begin
          if (pv && !rd_go) state <= S_PUT;
        end
        S_PUT: begin
          len   <= len + LW'(1);
          state <= S_FIN;
        end

        // shift entries down over the erased one
        S_DOWN: begin
          if (pv && !rd_go) begin
            len   <= len - LW'(1);
            state <= S_FIN;
          end
        end

        // search for the first match; remove-first then shifts down over it
        S_SCAN: begin
          if (pv) begin
            if (!keep) begin
              if (is_find) begin
                res_found <= pa;
                state     <= S_FIN;
              end else if (pa_nx < len) begin
                pos     <= pa;
                rp      <= pa_nx;
                rd_last <= len - LW'(1);
                rd_dn   <= 1'b0;
                rd_go   <= 1'b1;
                pv      <= 1'b0;
                state   <= S_DOWN;
              end else begin
                len   <= len - LW'(1);
                state <= S_FIN;
              end
            end else if (!rd_go) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_FIN;
            end
          end
        end

        // compact: copy each kept entry to the write pointer
        S_PACK: begin
          if (pv) begin
            if (keep) wp <= wp + LW'(1);
            if (!rd_go) begin
              len   <= keep ? (wp + LW'(1)) : wp;
              state <= S_FIN;
            end
          end
        end

        // hand the result to the output register when it is free
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_found  <= found_x[7:0];
            out_count  <= len_x[8:0];
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/ile_checker.sv]
// Port-level checks for the indexed list engine, bound to the top level.
// Depends on ile_pkg for status codes.
module ile_checker
  import ile_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic [7:0]  found_index,
  input logic [8:0]  count
);

  logic [8:0] last_count;

  // Track the count reported by the last response beat
  always_ff @(posedge clk) begin
    if (rst) last_count <= '0;
    else if (rsp_valid && rsp_ready) last_count <= count;
  end

  // Stalled response holds its status and count
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(count))
    else $error("response changed while stalled");

  // After a command is taken, the engine is not ready in the following cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken in back-to-back cycles");

  // A failed command leaves the length as it was
  a_fail_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> count == last_count)
    else $error("failed command changed the count");

  // An empty-list error reports no entries
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY) |-> count == 9'd0)
    else $error("empty status with nonzero count");

  // Only a successful find reports an index
  a_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (found_index != 8'd0) |-> status == ST_OK)
    else $error("index reported with error status");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .found_index (rsp.found_index),
  .count       (rsp.count)
);

[tb/indexed_list_engine_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the indexed list engine: a queue-fed command driver, a response
// monitor and a shadow list that predicts every response. Depends on ile_pkg and ile_if.sv.
module indexed_list_engine_tb;
  import ile_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PHASE_ITEMS = 475;
  localparam int MAX_REPORTS = 200;
  localparam logic [3:0] CMD_FIRST_FREE = 4'(CMD_REMOVE_ALL) + 4'd1;
  localparam logic [3:0] CMD_LAST_CODE = '1;
  localparam logic [31:0] VALUE_POOL [8] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h0000_0005, 32'h0000_002A, 32'h5555_AAAA
  };

  typedef struct {
    logic [3:0]  command;
    logic [8:0]  position;
    logic [31:0] value;
  } list_cmd_t;

  typedef struct {
    status_t    status;
    logic [7:0] found_index;
    logic [8:0] count;
  } list_rsp_t;

  logic clk;
  logic rst;
  logic cmd_taken = 1'b0;

  ile_cmd_if cmd_ch ();
  ile_rsp_if rsp_ch ();

  indexed_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  list_cmd_t   pend_q[$];
  list_rsp_t   rsp_expect_q[$];
  int          cmds_queued = 0;
  int          cmds_accepted = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  // Shadow copy of the list
  logic [31:0] shadow_mem [CAPACITY];
  int          shadow_len = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int locate_value(logic [31:0] v);
    for (int i = 0; i < shadow_len; i++)
      if (shadow_mem[i] == v) return i;
    return -1;
  endfunction

  function automatic status_t shadow_insert(int pos, logic [31:0] v);
    if (pos > shadow_len) return ST_BAD_INDEX;
    if (shadow_len >= CAPACITY) return ST_FULL;
    for (int i = shadow_len; i > pos; i--) shadow_mem[i] = shadow_mem[i - 1];
    shadow_mem[pos] = v;
    shadow_len++;
    return ST_OK;
  endfunction

  function automatic status_t shadow_erase(int pos);
    if (shadow_len == 0) return ST_EMPTY;
    if (pos >= shadow_len) return ST_BAD_INDEX;
    for (int i = pos; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i + 1];
    shadow_len--;
    return ST_OK;
  endfunction

  // Apply one command to the shadow list and build the response it should give
  function automatic list_rsp_t predict_list_cmd(logic [3:0] command, logic [8:0] position,
                                                 logic [31:0] value);
    list_rsp_t r;
    int        hit;
    int        keep;
    r.status = ST_OK;
    r.found_index = '0;
    case (command)
      CMD_INSERT_AT:  r.status = shadow_insert(int'(position), value);
      CMD_PUSH_FRONT: r.status = shadow_insert(0, value);
      CMD_PUSH_BACK:  r.status = shadow_insert(shadow_len, value);
      CMD_ERASE_AT:   r.status = shadow_erase(int'(position));
      CMD_POP_FRONT:  r.status = shadow_erase(0);
      CMD_POP_BACK: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else shadow_len--;
      end
      CMD_FIND: begin
        hit = locate_value(value);
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.found_index = 8'(hit);
      end
      CMD_REMOVE_FIRST: begin
        hit = locate_value(value);
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.status = shadow_erase(hit);
      end
      CMD_REMOVE_ALL: begin
        keep = 0;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_mem[i] != value) begin
            shadow_mem[keep] = shadow_mem[i];
            keep++;
          end
        end
        shadow_len = keep;
      end
      default: ;  // unused codes leave the list alone
    endcase
    r.count = 9'(shadow_len);
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2:    return VALUE_POOL[$urandom_range(0, 7)];
      3, 4, 5, 6: return 32'($urandom_range(0, 15));
      default:    return $urandom();
    endcase
  endfunction

  function automatic int pick_position(int cur);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 511);
    return $urandom_range(0, cur);
  endfunction

  task automatic queue_cmd(logic [3:0] command, int pos, logic [31:0] value);
    list_cmd_t it;
    it.command = command;
    it.position = 9'(pos);
    it.value = value;
    pend_q.push_back(it);
    cmds_queued++;
  endtask

  task automatic wait_accepted();
    while (cmds_accepted != cmds_queued) @(posedge clk);
  endtask

  task automatic wait_all_responses();
    wait_accepted();
    while (rsp_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("cycle %0d: %s", cycle_count, what);
  endtask

  // Drive command beats and response ready on the falling edge
  always @(negedge clk) begin
    list_cmd_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(1, 100) > stall_pct);
      // hold the beat until taken, then load the next one or idle
      if (!cmd_ch.valid || cmd_taken) begin
        if (pend_q.size() != 0 && $urandom_range(1, 100) > gap_pct) begin
          nxt = pend_q.pop_front();
          cmd_ch.valid    <= 1'b1;
          cmd_ch.command  <= nxt.command;
          cmd_ch.position <= nxt.position;
          cmd_ch.value    <= nxt.value;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Predict on each command beat, check each response beat
  always @(posedge clk) begin
    list_rsp_t want;
    cmd_taken <= cmd_ch.valid && cmd_ch.ready && !rst;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        rsp_expect_q.push_back(predict_list_cmd(cmd_ch.command, cmd_ch.position,
                                                cmd_ch.value));
        cmds_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (rsp_expect_q.size() == 0) begin
          report_mismatch($sformatf("response with none pending: status %0d count %0d",
                                    rsp_ch.status, rsp_ch.count));
        end else begin
          want = rsp_expect_q.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.found_index !== want.found_index ||
              rsp_ch.count !== want.count)
            report_mismatch($sformatf(
              "got status %0d index %0d count %0d, want status %0d index %0d count %0d",
              rsp_ch.status, rsp_ch.found_index, rsp_ch.count,
              want.status, want.found_index, want.count));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses pending", cycle_count,
               rsp_expect_q.size());
      $display("FAIL indexed_list_engine");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int phase_target;
    int est;
    int n;
    int r;
    int grow;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.position = '0;
    cmd_ch.value = '0;
    rsp_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: the empty, not-found and bad-index paths first
    queue_cmd(CMD_POP_BACK, 0, 0);
    queue_cmd(CMD_POP_FRONT, 0, 0);
    queue_cmd(CMD_ERASE_AT, 0, 0);
    queue_cmd(CMD_FIND, 0, 32'h0000_0005);
    queue_cmd(CMD_REMOVE_FIRST, 0, 32'h0000_0005);
    queue_cmd(CMD_REMOVE_ALL, 0, 32'h0000_0005);
    queue_cmd(CMD_INSERT_AT, 1, 32'h0000_0001);
    // Build a short list with extreme values and duplicates, then find, erase and remove
    queue_cmd(CMD_INSERT_AT, 0, 32'h8000_0000);
    queue_cmd(CMD_PUSH_BACK, 511, 32'h7FFF_FFFF);
    queue_cmd(CMD_PUSH_FRONT, 256, 32'hFFFF_FFFF);
    queue_cmd(CMD_INSERT_AT, 3, 32'h0000_0000);
    queue_cmd(CMD_INSERT_AT, 1, 32'h7FFF_FFFF);
    queue_cmd(CMD_FIND, 0, 32'h7FFF_FFFF);
    queue_cmd(CMD_FIND, 0, 32'h0000_0000);
    queue_cmd(CMD_ERASE_AT, 5, 0);
    queue_cmd(CMD_ERASE_AT, 511, 0);
    queue_cmd(CMD_INSERT_AT, 511, 32'h1234_5678);
    queue_cmd(CMD_REMOVE_FIRST, 0, 32'h7FFF_FFFF);
    queue_cmd(CMD_LAST_CODE, 511, 32'hDEAD_BEEF);
    queue_cmd(CMD_FIRST_FREE, 0, 32'h0000_0000);
    queue_cmd(CMD_REMOVE_ALL, 0, 32'hFFFF_FFFF);
    queue_cmd(CMD_ERASE_AT, 0, 0);
    queue_cmd(CMD_POP_FRONT, 0, 0);
    queue_cmd(CMD_POP_BACK, 0, 0);
    queue_cmd(CMD_FIND, 0, 32'h0001_2345);
    wait_all_responses();

    // Random phases: no idling, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 79; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 79; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      phase_target = cmds_queued + PHASE_ITEMS;
      while (cmds_queued < phase_target) begin
        wait_accepted();
        est = shadow_len;
        r = $urandom_range(1, 100);
        if (r <= 6) begin
          // fill to capacity, then hit the full list
          n = CAPACITY - est;
          for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
              0:       queue_cmd(CMD_PUSH_FRONT, $urandom_range(0, 511), pick_value());
              1:       queue_cmd(CMD_INSERT_AT, $urandom_range(0, est + k), pick_value());
              default: queue_cmd(CMD_PUSH_BACK, $urandom_range(0, 511), pick_value());
            endcase
          end
          queue_cmd(CMD_PUSH_FRONT, 0, pick_value());
          queue_cmd(CMD_PUSH_BACK, 0, pick_value());
          queue_cmd(CMD_INSERT_AT, CAPACITY, pick_value());
          queue_cmd(CMD_INSERT_AT, CAPACITY + 1, pick_value());
          queue_cmd(CMD_FIND, 0, pick_value());
          queue_cmd(CMD_REMOVE_FIRST, 0, pick_value());
          queue_cmd(CMD_POP_BACK, 0, 0);
          queue_cmd(CMD_PUSH_BACK, 0, pick_value());
          queue_cmd(CMD_ERASE_AT, CAPACITY - 1, 0);
          queue_cmd(CMD_REMOVE_ALL, 0, VALUE_POOL[$urandom_range(0, 7)]);
        end else if (r <= 12) begin
          // drain to empty and poke the empty list
          for (int k = 0; k < est + 2; k++) begin
            case ($urandom_range(0, 5))
              0:       queue_cmd(CMD_POP_FRONT, $urandom_range(0, 511), pick_value());
              1:       queue_cmd(CMD_ERASE_AT, (est - k > 1) ? $urandom_range(0, est - k - 1) : 0,
                                 pick_value());
              2:       queue_cmd(CMD_REMOVE_FIRST, 0, pick_value());
              default: queue_cmd(CMD_POP_BACK, $urandom_range(0, 511), pick_value());
            endcase
          end
        end else begin
          // mixed traffic, steered toward a moderate length
          for (int k = 0; k < 16; k++) begin
            grow = (est < 8) ? 70 : (est > 48) ? 15 : 40;
            r = $urandom_range(0, 99);
            if (r < grow) begin
              case ($urandom_range(0, 2))
                0:       queue_cmd(CMD_INSERT_AT, pick_position(est), pick_value());
                1:       queue_cmd(CMD_PUSH_FRONT, $urandom_range(0, 511), pick_value());
                default: queue_cmd(CMD_PUSH_BACK, $urandom_range(0, 511), pick_value());
              endcase
              if (est < CAPACITY) est++;
            end else if (r < grow + ((est > 48) ? 45 : 30)) begin
              case ($urandom_range(0, 3))
                0:       queue_cmd(CMD_ERASE_AT, pick_position(est), pick_value());
                1:       queue_cmd(CMD_POP_FRONT, $urandom_range(0, 511), pick_value());
                2:       queue_cmd(CMD_POP_BACK, $urandom_range(0, 511), pick_value());
                default: queue_cmd(CMD_REMOVE_FIRST, $urandom_range(0, 511), pick_value());
              endcase
              if (est > 0) est--;
            end else begin
              case ($urandom_range(0, 19))
                0:          queue_cmd(4'($urandom_range(CMD_FIRST_FREE, CMD_LAST_CODE)),
                                      $urandom_range(0, 511), $urandom());
                1, 2, 3, 4: queue_cmd(CMD_REMOVE_ALL, $urandom_range(0, 511), pick_value());
                default:    queue_cmd(CMD_FIND, $urandom_range(0, 511), pick_value());
              endcase
            end
          end
        end
      end
      // pause the sender until every response of the phase is back
      wait_all_responses();
    end

    // Flush: watch for stray responses
    gap_pct = 0;
    stall_pct = 0;
    wait_all_responses();
    repeat (CAPACITY + 16) @(posedge clk);
    if (mismatch_count == 0 && rsp_expect_q.size() == 0)
      $display("PASS indexed_list_engine");
    else
      $display("FAIL indexed_list_engine");
    $finish;
  end

endmodule

[sim.f]
sv/ile_pkg.sv
sv/ile_if.sv
sv/indexed_list_engine.sv
sv/ile_checker.sv
tb/indexed_list_engine_tb.sv
